FILE: rtl/block_cyclic_partition_intervals_assert.svh
// Assertion macros used by the checker of this block.
`ifndef BLOCK_CYCLIC_PARTITION_INTERVALS_ASSERT_SVH
`define BLOCK_CYCLIC_PARTITION_INTERVALS_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BCPI_ASSERT_NOW(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BCPI_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

FILE: rtl/bcpi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bcpi_pkg;

	// fixed field widths
	localparam int OW  = 21;
	localparam int PW  = 11;
	localparam int IDW = 10;
	localparam int SW  = 17;
	localparam int STW = 20;
	localparam int CIW = 3;

	// register indexes
	localparam logic [CIW-1:0] REG_DIM_START  = 3'd0;
	localparam logic [CIW-1:0] REG_DIM_LENGTH = 3'd1;
	localparam logic [CIW-1:0] REG_BLOCK_SIZE = 3'd2;
	localparam logic [CIW-1:0] REG_PROC_COUNT = 3'd3;

	// operations
	localparam logic OP_SINGLE = 1'b0;
	localparam logic OP_RANGE  = 1'b1;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_START,
		SEQ_DIV_PARTS,
		SEQ_MUL,
		SEQ_DIV_FULL,
		SEQ_DIV_EXTRA,
		SEQ_FIN
	} seq_state_t;

	typedef struct packed {
		logic           operation;
		logic [IDW-1:0] first_part;
		logic [IDW-1:0] last_part;
	} in_word_t;

	typedef struct packed {
		logic [OW-1:0] interval_begin;
		logic [OW-1:0] interval_length;
		logic [OW-1:0] interval_period;
		logic [OW-1:0] interval_count;
		logic [OW-1:0] local_entries;
		logic [PW-1:0] part_total;
		logic          last_result;
	} out_word_t;

endpackage
`default_nettype wire

FILE: rtl/block_cyclic_partition_intervals.sv
`timescale 1ns / 1ps
`default_nettype none
// Block-cyclic interval generator. Each input word yields one or two result words
// (last_result marks the final one); a query takes three pipeline stages plus the
// output register, and one query enters per cycle when the output is not stalled,
// no second result is pending and no configuration write or rebuild is under way.
// A query with two results holds the pipeline while the second result leaves.
// After reset and after every configuration write the derived values (part count,
// stride, full strides, spill) are rebuilt by a shared LW-bit bit-serial divider
// (LW is the wider of INDEX_BITS+1 and 21) in three divisions and the START, MUL
// and FIN states, during which in_stall is high. cfg_ready is always high.
module block_cyclic_partition_intervals #(
	parameter int MAX_PARTS  = 1024,
	parameter int INDEX_BITS = 20
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  bcpi_pkg::in_word_t          in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output bcpi_pkg::out_word_t         out_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [bcpi_pkg::CIW-1:0]    cfg_index,
	input  logic [bcpi_pkg::OW-1:0]     cfg_data
);
	import bcpi_pkg::*;

	localparam int LW = (INDEX_BITS + 1 > OW) ? INDEX_BITS + 1 : OW;
	localparam int CW = $clog2(LW + 1);
	localparam logic [LW-1:0] LEN_CAP = LW'(64'd1 << INDEX_BITS);

	function automatic out_word_t mk(input logic [LW-1:0] b, input logic [LW-1:0] l,
			input logic [LW-1:0] pd, input logic [LW-1:0] c, input logic [LW-1:0] lo,
			input logic [PW-1:0] pt, input logic lst);
		out_word_t w;
		w.interval_begin  = b[OW-1:0];
		w.interval_length = l[OW-1:0];
		w.interval_period = pd[OW-1:0];
		w.interval_count  = c[OW-1:0];
		w.local_entries   = lo[OW-1:0];
		w.part_total      = pt;
		w.last_result     = lst;
		return w;
	endfunction

	// configuration registers
	logic [STW-1:0] dim_start_q;
	logic [OW-1:0]  dim_length_q;
	logic [SW-1:0]  block_size_q;
	logic [PW-1:0]  proc_count_q;
	logic           cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_start_q  <= '0;
			dim_length_q <= OW'(1);
			block_size_q <= SW'(1);
			proc_count_q <= PW'(1);
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_DIM_START:  dim_start_q  <= cfg_data[STW-1:0];
				REG_DIM_LENGTH: dim_length_q <= cfg_data;
				REG_BLOCK_SIZE: block_size_q <= cfg_data[SW-1:0];
				REG_PROC_COUNT: proc_count_q <= cfg_data[PW-1:0];
				default: ;
			endcase
		end
	end

	// derived values
	logic [LW-1:0] len_q, size_q, stride_q, full_q, partial_q, extra_q, rem_q;
	logic [LW-1:0] fs_q, fsize_q, spb_q;
	logic [PW-1:0] parts_q;
	logic [LW-1:0] len_c, size_c, stride_c, parts_c;

	always_comb begin
		len_c  = (LW'(dim_length_q) > LEN_CAP) ? LEN_CAP : LW'(dim_length_q);
		size_c = (block_size_q == '0) ? LW'(1) : LW'(block_size_q);
		stride_c = LW'(size_q[SW-1:0] * parts_q);
	end

	// shared bit-serial divider
	logic [LW-1:0] dv_n_q, dv_d_q, dv_r_q, dv_q_q;
	logic [CW-1:0] dv_cnt_q;
	logic [LW-1:0] dv_rs, dv_diff, dv_load_n, dv_load_d;
	logic          dv_ge, dv_done, dv_load;

	always_comb begin
		dv_rs   = {dv_r_q[LW-2:0], dv_n_q[LW-1]};
		dv_ge   = dv_rs >= dv_d_q;
		dv_diff = dv_rs - dv_d_q;
		dv_done = dv_cnt_q == '0;
	end

	// sequencer
	seq_state_t state_q, state_d;
	logic       busy;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SEQ_IDLE:      state_d = SEQ_IDLE;
			SEQ_START:     state_d = SEQ_DIV_PARTS;
			SEQ_DIV_PARTS: if (dv_done) state_d = SEQ_MUL;
			SEQ_MUL:       state_d = SEQ_DIV_FULL;
			SEQ_DIV_FULL:  if (dv_done) state_d = SEQ_DIV_EXTRA;
			SEQ_DIV_EXTRA: if (dv_done) state_d = SEQ_FIN;
			SEQ_FIN:       state_d = SEQ_IDLE;
			default:       state_d = SEQ_START;
		endcase
		if (cfg_wr) state_d = SEQ_START;
	end

	always_comb begin
		busy      = state_q != SEQ_IDLE;
		dv_load   = 1'b0;
		dv_load_n = len_c;
		dv_load_d = size_c;
		unique case (state_q)
			SEQ_START: dv_load = 1'b1;
			SEQ_MUL: begin
				dv_load   = 1'b1;
				dv_load_n = len_q;
				dv_load_d = stride_c;
			end
			SEQ_DIV_FULL: begin
				dv_load   = dv_done;
				dv_load_n = dv_r_q;
				dv_load_d = size_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= SEQ_START;
			dv_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (dv_load) dv_cnt_q <= CW'(LW);
			else if (!dv_done) dv_cnt_q <= dv_cnt_q - CW'(1);
		end
	end

	// clamp the raw part count
	always_comb begin
		parts_c = dv_q_q;
		if (parts_c > LW'(proc_count_q)) parts_c = LW'(proc_count_q);
		if (parts_c > LW'(MAX_PARTS)) parts_c = LW'(MAX_PARTS);
		if (parts_c == '0) parts_c = LW'(1);
	end

	always_ff @(posedge clk) begin
		if (dv_load) begin
			dv_n_q <= dv_load_n;
			dv_d_q <= dv_load_d;
			dv_r_q <= '0;
			dv_q_q <= '0;
		end else if (!dv_done) begin
			dv_n_q <= {dv_n_q[LW-2:0], 1'b0};
			dv_q_q <= {dv_q_q[LW-2:0], dv_ge};
			dv_r_q <= dv_ge ? dv_diff : dv_rs;
		end
		if (state_q == SEQ_START) begin
			len_q  <= len_c;
			size_q <= size_c;
		end
		if (state_q == SEQ_DIV_PARTS && dv_done) parts_q <= PW'(parts_c);
		if (state_q == SEQ_MUL) stride_q <= stride_c;
		if (state_q == SEQ_DIV_FULL && dv_done) begin
			full_q    <= dv_q_q;
			partial_q <= dv_r_q;
		end
		if (state_q == SEQ_DIV_EXTRA && dv_done) begin
			extra_q <= dv_q_q;
			rem_q   <= dv_r_q;
		end
		if (state_q == SEQ_FIN) begin
			fsize_q <= LW'(full_q * size_q[SW-1:0]);
			fs_q    <= len_q - partial_q;
			spb_q   <= LW'(dim_start_q) + len_q - rem_q;
		end
	end

	// pipeline control
	logic out_valid_q, pend_v_q, out_free, en, acc;
	out_word_t out_q, pend_q;
	logic v_s1, v_s2, v_s3;

	assign out_free  = !out_valid_q || !out_stall;
	assign en        = out_free && !pend_v_q;
	assign in_stall  = !en || busy || cfg_valid;
	assign acc       = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1: clamp part ids
	logic [PW-1:0]  pm1;
	logic [IDW-1:0] fc, lc;
	logic           op_s1;
	logic [IDW-1:0] f_s1, l_s1;

	always_comb begin
		pm1 = parts_q - PW'(1);
		fc  = (PW'(in_data.first_part) > pm1) ? pm1[IDW-1:0] : in_data.first_part;
		lc  = (PW'(in_data.last_part) > pm1) ? pm1[IDW-1:0] : in_data.last_part;
		if (lc < fc) lc = fc;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= in_data.operation;
			f_s1  <= fc;
			l_s1  <= lc;
		end
	end

	// stage 2: block offsets and compares
	logic [PW-1:0] span;
	logic          op_s2, gt_s2, eq_s2, gtl_s2, whole_s2;
	logic [LW-1:0] prodf_s2, prods_s2;

	assign span = PW'(l_s1) - PW'(f_s1) + PW'(1);

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2    <= op_s1;
			prodf_s2 <= LW'(size_q[SW-1:0] * f_s1);
			prods_s2 <= LW'(size_q[SW-1:0] * span);
			gt_s2    <= extra_q > LW'(f_s1);
			eq_s2    <= extra_q == LW'(f_s1);
			gtl_s2   <= extra_q > LW'(l_s1);
			whole_s2 <= span == parts_q;
		end
	end

	// stage 3: build result words
	logic [LW-1:0] bgn, cnt0, loc, cnt1, spv;
	logic          spill0, sp_ok, two_c;
	out_word_t     r0_c, r1_c, r0_s3, r1_s3;
	logic          two_s3;

	always_comb begin
		bgn    = LW'(dim_start_q) + prodf_s2;
		cnt0   = full_q + LW'(gt_s2);
		loc    = fsize_q + (gt_s2 ? size_q : (eq_s2 ? rem_q : '0));
		spill0 = eq_s2 && (rem_q != '0);
		cnt1   = full_q + LW'(gtl_s2);
		sp_ok  = !gtl_s2 && (partial_q > prodf_s2);
		spv    = partial_q - prodf_s2;
		if (op_s2 == OP_SINGLE) begin
			r0_c  = mk(bgn, size_q, stride_q, cnt0, loc, parts_q, !spill0);
			r1_c  = mk(spb_q, rem_q, rem_q, LW'(1), loc, parts_q, 1'b1);
			two_c = spill0;
		end else if (whole_s2) begin
			r0_c  = mk(LW'(dim_start_q), len_q, len_q, LW'(1), '0, parts_q, 1'b1);
			r1_c  = r0_c;
			two_c = 1'b0;
		end else begin
			r0_c  = mk(bgn, prods_s2, stride_q, cnt1, '0, parts_q, !sp_ok);
			r1_c  = mk(bgn + fs_q, spv, spv, LW'(1), '0, parts_q, 1'b1);
			two_c = sp_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r0_s3  <= r0_c;
			r1_s3  <= r1_c;
			two_s3 <= two_c;
		end
	end

	// output register and pending second word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_v_q    <= 1'b0;
		end else if (out_free) begin
			if (pend_v_q) begin
				out_valid_q <= 1'b1;
				pend_v_q    <= 1'b0;
			end else begin
				out_valid_q <= v_s3;
				pend_v_q    <= v_s3 && two_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_v_q) begin
				out_q <= pend_q;
			end else if (v_s3) begin
				out_q  <= r0_s3;
				pend_q <= r1_s3;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/bcpi_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "block_cyclic_partition_intervals_assert.svh"
module bcpi_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     out_valid,
	input logic                     out_stall,
	input bcpi_pkg::out_word_t      out_data
);

	// stalled word holds
	`BCPI_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled output word changed")

	// part count is never zero
	`BCPI_ASSERT_NOW(a_parts_nonzero, out_valid, out_data.part_total != '0, "part_total is zero")

	// a second word follows right after a non-final word
	`BCPI_ASSERT_NEXT(a_second_follows, out_valid && !out_stall && !out_data.last_result, out_valid, "second result word missing")

	// both words of one query share the part count
	`BCPI_ASSERT_NEXT(a_pair_parts, out_valid && !out_stall && !out_data.last_result, out_data.part_total == $past(out_data.part_total), "part_total differs within a query")

endmodule

bind block_cyclic_partition_intervals bcpi_checker u_bcpi_checker (.*);
`default_nettype wire
